// ----- src/pdr_change_event_decoder_unit_assert.svh -----
// Assertion macros shared by the decoder modules.
`ifndef PDR_CHANGE_EVENT_DECODER_UNIT_ASSERT_SVH
`define PDR_CHANGE_EVENT_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTH
`define PDR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PDR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PDR_ASSERT(lbl, clk, rst_n, prop, msg)
`define PDR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ----- src/pdr_ced_pkg.sv -----
`default_nettype none

package pdr_ced_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned OUT_DATA_W  = 72;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECORDS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 8'd1;

    localparam logic [7:0] MAX_RECORDS_RST = 8'd8;
    localparam logic [7:0] MAX_ENTRIES_RST = 8'd64;

    localparam logic [7:0] FMT_REFRESH_ENTIRE = 8'd0;
    localparam logic [7:0] FMT_TYPES          = 8'd1;
    localparam logic [7:0] FMT_HANDLES        = 8'd2;
    localparam logic [7:0] OP_REFRESH_ALL     = 8'd0;
    localparam logic [7:0] OP_HIGHEST         = 8'd3;

    localparam logic KIND_ENTRY  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic        ent_vld;
        logic [7:0]  rec_idx;
        logic [7:0]  op;
        logic [31:0] value;
        logic        sts_vld;
        logic [7:0]  fmt;
        logic [7:0]  cnt;
        logic        sts;
    } t_q_item;

endpackage

`default_nettype wire

// ----- src/pdr_ced_fifo.sv -----
`default_nettype none

`include "pdr_change_event_decoder_unit_assert.svh"

module pdr_ced_fifo #(
    parameter int unsigned DEPTH = pdr_ced_pkg::QUEUE_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire pdr_ced_pkg::t_q_item i_item,
    input  wire logic                 i_pop,
    output logic                      o_full,
    output logic                      o_head_vld,
    output pdr_ced_pkg::t_q_item      o_head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    pdr_ced_pkg::t_q_item r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_head_vld = (r_count != '0);
    assign o_head     = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `PDR_ASSERT_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full, "push into a full queue")
    `PDR_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && !o_head_vld, "pop from an empty queue")

endmodule

`default_nettype wire

// ----- src/pdr_ced_front.sv -----
`default_nettype none

`include "pdr_change_event_decoder_unit_assert.svh"

module pdr_ced_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    input  wire logic [pdr_ced_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [7:0]                          i_cfg_data,
    input  wire logic                                i_in_vld,
    input  wire logic [7:0]                          i_data_byte,
    input  wire logic                                i_last_byte,
    input  wire logic                                i_q_full,
    output logic                                     o_in_rdy,
    output logic                                     o_push,
    output pdr_ced_pkg::t_q_item                     o_item
);

    localparam logic [2:0] PH_FORMAT  = 3'd0;
    localparam logic [2:0] PH_COUNT   = 3'd1;
    localparam logic [2:0] PH_OP      = 3'd2;
    localparam logic [2:0] PH_ENTRIES = 3'd3;
    localparam logic [2:0] PH_BYTES   = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

    logic [7:0]  r_max_records;
    logic [7:0]  r_max_entries;
    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_fmt, n_fmt;
    logic [7:0]  r_cnt, n_cnt;
    logic [7:0]  r_rec_done, n_rec_done;
    logic [7:0]  r_cur_op, n_cur_op;
    logic [7:0]  r_prev_op, n_prev_op;
    logic [7:0]  r_ent_left, n_ent_left;
    logic [1:0]  r_pos, n_pos;
    logic [23:0] r_part, n_part;
    logic        r_err, n_err;
    logic        w_ent;
    logic        w_accept;
    logic [7:0]  w_b;

    assign w_b      = i_data_byte;
    assign o_in_rdy = !i_q_full;
    assign w_accept = i_in_vld && o_in_rdy;
    assign o_push   = w_accept && (w_ent || i_last_byte);

    always_comb begin
        n_phase    = r_phase;
        n_fmt      = r_fmt;
        n_cnt      = r_cnt;
        n_rec_done = r_rec_done;
        n_cur_op   = r_cur_op;
        n_prev_op  = r_prev_op;
        n_ent_left = r_ent_left;
        n_pos      = r_pos;
        n_part     = r_part;
        n_err      = r_err;
        w_ent      = 1'b0;

        case (r_phase)
            PH_FORMAT: begin
                n_fmt   = w_b;
                n_phase = PH_COUNT;
            end
            PH_COUNT: begin
                n_cnt = w_b;
                if (r_fmt == pdr_ced_pkg::FMT_REFRESH_ENTIRE) begin
                    n_err   = r_err || (w_b != 8'd0);
                    n_phase = PH_DONE;
                end else if (r_fmt != pdr_ced_pkg::FMT_TYPES &&
                             r_fmt != pdr_ced_pkg::FMT_HANDLES) begin
                    n_err   = 1'b1;
                    n_phase = PH_DONE;
                end else if (w_b > r_max_records) begin
                    n_err   = 1'b1;
                    n_phase = PH_DONE;
                end else begin
                    n_phase = (w_b == 8'd0) ? PH_DONE : PH_OP;
                end
            end
            PH_OP: begin
                n_cur_op = w_b;
                if (w_b > pdr_ced_pkg::OP_HIGHEST ||
                    (r_fmt == pdr_ced_pkg::FMT_HANDLES && w_b == pdr_ced_pkg::OP_REFRESH_ALL) ||
                    (r_rec_done != 8'd0 && w_b < r_prev_op)) begin
                    n_err   = 1'b1;
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_ENTRIES;
                end
            end
            PH_ENTRIES: begin
                if (w_b > r_max_entries) begin
                    n_err   = 1'b1;
                    n_phase = PH_DONE;
                end else begin
                    n_prev_op  = r_cur_op;
                    n_ent_left = w_b;
                    n_pos      = 2'd0;
                    n_part     = 24'd0;
                    if (w_b == 8'd0) begin
                        n_rec_done = r_rec_done + 8'd1;
                        n_phase    = (n_rec_done == r_cnt) ? PH_DONE : PH_OP;
                    end else begin
                        n_phase = PH_BYTES;
                    end
                end
            end
            PH_BYTES: begin
                case (r_pos)
                    2'd0: begin
                        n_part[7:0] = w_b;
                        n_pos       = 2'd1;
                    end
                    2'd1: begin
                        n_part[15:8] = w_b;
                        n_pos        = 2'd2;
                    end
                    2'd2: begin
                        n_part[23:16] = w_b;
                        n_pos         = 2'd3;
                    end
                    default: begin
                        w_ent      = 1'b1;
                        n_pos      = 2'd0;
                        n_part     = 24'd0;
                        n_ent_left = r_ent_left - 8'd1;
                        if (n_ent_left == 8'd0) begin
                            n_rec_done = r_rec_done + 8'd1;
                            n_phase    = (n_rec_done == r_cnt) ? PH_DONE : PH_OP;
                        end
                    end
                endcase
            end
            default: begin
            end
        endcase

        o_item.ent_vld = w_ent;
        o_item.rec_idx = r_rec_done;
        o_item.op      = r_cur_op;
        o_item.value   = {w_b, r_part};
        o_item.sts_vld = i_last_byte;
        o_item.fmt     = n_fmt;
        o_item.cnt     = n_cnt;
        o_item.sts     = n_err || (n_phase != PH_DONE);

        if (i_last_byte) begin
            n_phase    = PH_FORMAT;
            n_fmt      = 8'd0;
            n_cnt      = 8'd0;
            n_rec_done = 8'd0;
            n_cur_op   = 8'd0;
            n_prev_op  = 8'd0;
            n_ent_left = 8'd0;
            n_pos      = 2'd0;
            n_part     = 24'd0;
            n_err      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_records <= pdr_ced_pkg::MAX_RECORDS_RST;
            r_max_entries <= pdr_ced_pkg::MAX_ENTRIES_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == pdr_ced_pkg::CFG_MAX_RECORDS) begin
                r_max_records <= i_cfg_data;
            end else if (i_cfg_index == pdr_ced_pkg::CFG_MAX_ENTRIES) begin
                r_max_entries <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FORMAT;
            r_fmt      <= 8'd0;
            r_cnt      <= 8'd0;
            r_rec_done <= 8'd0;
            r_cur_op   <= 8'd0;
            r_prev_op  <= 8'd0;
            r_ent_left <= 8'd0;
            r_pos      <= 2'd0;
            r_part     <= 24'd0;
            r_err      <= 1'b0;
        end else if (w_accept) begin
            r_phase    <= n_phase;
            r_fmt      <= n_fmt;
            r_cnt      <= n_cnt;
            r_rec_done <= n_rec_done;
            r_cur_op   <= n_cur_op;
            r_prev_op  <= n_prev_op;
            r_ent_left <= n_ent_left;
            r_pos      <= n_pos;
            r_part     <= n_part;
            r_err      <= n_err;
        end
    end

    `PDR_ASSERT(a_last_restarts, i_clk, i_rst_n, w_accept && i_last_byte |=> r_phase == PH_FORMAT && !r_err, "last beat did not restart the parser")
    `PDR_ASSERT(a_error_done, i_clk, i_rst_n, r_err |-> r_phase == PH_DONE, "error seen outside the done phase")

endmodule

`default_nettype wire

// ----- src/pdr_ced_back.sv -----
`default_nettype none

`include "pdr_change_event_decoder_unit_assert.svh"

module pdr_ced_back (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_head_vld,
    input  wire pdr_ced_pkg::t_q_item                 i_head,
    output logic                                      o_pop,
    input  wire logic                                 i_tready,
    output logic                                      o_tvalid,
    output logic                                      o_tuser,
    output logic                                      o_tlast,
    output logic [pdr_ced_pkg::OUT_DATA_W-1:0]        o_tdata
);

    logic                                r_vld, n_vld;
    logic                                r_ent_done, n_ent_done;
    logic                                r_kind, n_kind;
    logic [pdr_ced_pkg::OUT_DATA_W-1:0]  r_data, n_data;
    logic                                w_load;
    logic                                w_emit_ent;

    assign w_load     = i_head_vld && (!r_vld || i_tready);
    assign w_emit_ent = i_head.ent_vld && !r_ent_done;
    assign o_pop      = w_load && !(w_emit_ent && i_head.sts_vld);

    always_comb begin
        n_vld      = r_vld && !i_tready;
        n_ent_done = r_ent_done;
        n_kind     = r_kind;
        n_data     = r_data;
        if (w_load) begin
            n_vld      = 1'b1;
            n_ent_done = w_emit_ent && i_head.sts_vld;
            if (w_emit_ent) begin
                n_kind = pdr_ced_pkg::KIND_ENTRY;
                n_data = {7'd0, 1'b0, 8'd0, 8'd0, i_head.value, i_head.op, i_head.rec_idx};
            end else begin
                n_kind = pdr_ced_pkg::KIND_STATUS;
                n_data = {7'd0, i_head.sts, i_head.cnt, i_head.fmt, 32'd0, 8'd0, 8'd0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_ent_done <= 1'b0;
        end else begin
            r_vld      <= n_vld;
            r_ent_done <= n_ent_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_data <= n_data;
    end

    assign o_tvalid = r_vld;
    assign o_tuser  = r_kind;
    assign o_tlast  = (r_kind == pdr_ced_pkg::KIND_STATUS);
    assign o_tdata  = r_data;

    `PDR_ASSERT(a_split_head, i_clk, i_rst_n, r_ent_done |-> i_head_vld && i_head.sts_vld, "split item lost its status half")

endmodule

`default_nettype wire

// ----- src/pdr_change_event_decoder_unit.sv -----
`default_nettype none

// Channel   Direction  Payload (lowest bit first)
// s_axis    in         tdata: data_byte[7:0]; tlast: last_byte
// m_axis    out        tdata: record_index, operation, entry_value, event_format,
//                      record_count, status, zero pad; tuser: result_kind;
//                      tlast: last_result
// cfg       in         index 0 max_records, 1 max_entries; data 8 bits
//
// One input beat is taken per cycle while the result queue has room.
// A beat that completes an entry on the last byte yields two results, sent
// one after the other from the same queue slot.
// A result passes through the result queue and then the output register before it is offered.
// Reset is synchronous and active low; the configuration port never stalls.

module pdr_change_event_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = pdr_ced_pkg::QUEUE_DEPTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [7:0]                          s_axis_tdata,  // data_byte
    input  wire logic                                s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // record_index, operation, entry_value, event_format, record_count, status
    output logic [pdr_ced_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                     m_axis_tuser,  // result_kind
    output logic                                     m_axis_tlast,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [pdr_ced_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [7:0]                          i_cfg_data
);

    logic                 w_push;
    logic                 w_pop;
    logic                 w_full;
    logic                 w_head_vld;
    pdr_ced_pkg::t_q_item w_item;
    pdr_ced_pkg::t_q_item w_head;

    assign o_cfg_ready = 1'b1;

    pdr_ced_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_vld    (s_axis_tvalid),
        .i_data_byte (s_axis_tdata),
        .i_last_byte (s_axis_tlast),
        .i_q_full    (w_full),
        .o_in_rdy    (s_axis_tready),
        .o_push      (w_push),
        .o_item      (w_item)
    );

    pdr_ced_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_item     (w_item),
        .i_pop      (w_pop),
        .o_full     (w_full),
        .o_head_vld (w_head_vld),
        .o_head     (w_head)
    );

    pdr_ced_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head_vld (w_head_vld),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .i_tready   (m_axis_tready),
        .o_tvalid   (m_axis_tvalid),
        .o_tuser    (m_axis_tuser),
        .o_tlast    (m_axis_tlast),
        .o_tdata    (m_axis_tdata)
    );

endmodule

`default_nettype wire
